/* hdl/cctod_pkg.sv */
// ----------------------------------------------------------------------------
// Cycle count to time of day: shared types and constants
// Widths, register indexes and the word carried between divider cells.
// ----------------------------------------------------------------------------
package cctod_pkg;

    localparam int CountW  = 64;
    localparam int RateW   = 34;
    localparam int OsecW   = 40;
    localparam int NsW     = 30;
    localparam int UsW     = 20;
    localparam int IdxW    = 3;
    localparam int CfgW    = 64;

    // Cells in the seconds divider (one per count bit) and in the fraction
    // divider (one per nanosecond quotient bit).
    localparam int CellsA  = CountW;
    localparam int CellsB  = NsW;

    localparam logic [NsW-1:0]  NS_ONE_SEC = NsW'(1000000000);
    localparam logic [NsW-1:0]  NS_MAX     = NsW'(999999999);
    localparam logic [RateW-1:0] RATE_RESET = RateW'(1000000000);

    // floor(n / 1000) = (n * US_RECIP) >> US_SHIFT for every n below 2^30.
    localparam int              US_SHIFT = 40;
    localparam logic [30:0]     US_RECIP = 31'd1099511628;

    typedef enum logic [IdxW-1:0] {
        REG_ORIGIN_SEC  = 3'd0,
        REG_ORIGIN_NS   = 3'd1,
        REG_RATE        = 3'd2,
        REG_LOCAL_EN    = 3'd3
    } cfg_idx_t;

    // Word handed from one restoring-division cell to the next.
    typedef struct packed {
        logic              valid;
        logic              fb;
        logic [RateW-1:0]  rem;
        logic [CountW-1:0] dvd;
        logic [CountW-1:0] quo;
        logic [CountW-1:0] aux;
    } cell_t;

endpackage

/* hdl/cctod_cell.sv */
// ----------------------------------------------------------------------------
// Divider cell
// One restoring-division step: shifts in the next dividend bit, subtracts
// the rate where it fits and registers the word for the next cell.
// ----------------------------------------------------------------------------
module cctod_cell
    import cctod_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  logic [RateW-1:0] rate,
    input  cell_t            cell_in,
    output cell_t            cell_out
);

    cell_t            word_reg;
    cell_t            word_next;
    logic             valid_reg;
    logic [RateW:0]   trial;
    logic [RateW:0]   diff;

    always_comb
    begin
        trial     = {cell_in.rem, cell_in.dvd[CountW-1]};
        diff      = trial - {1'b0, rate};
        word_next = cell_in;
        word_next.dvd = {cell_in.dvd[CountW-2:0], 1'b0};
        if (trial >= {1'b0, rate})
        begin
            word_next.rem = diff[RateW-1:0];
            word_next.quo = {cell_in.quo[CountW-2:0], 1'b1};
        end
        else
        begin
            word_next.rem = trial[RateW-1:0];
            word_next.quo = {cell_in.quo[CountW-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= cell_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            word_reg <= word_next;
        end
    end

    always_comb
    begin
        cell_out       = word_reg;
        cell_out.valid = valid_reg;
    end

endmodule

/* hdl/cycle_count_to_time_of_day.sv */
// ----------------------------------------------------------------------------
// Cycle count to time of day
// Converts a cycle count into seconds, nanoseconds and microseconds.
// ----------------------------------------------------------------------------
// One word is accepted every cycle unless a result waits stalled at the
// output, which holds the whole pipeline. In order, 64 cells divide the
// count by the rate one quotient bit at a time, one stage scales the
// remainder by 10^9, 30 further cells divide that product by the rate, one
// stage adds the origin and normalises the carry, and a last stage derives
// microseconds. The user must write configuration only when the block is
// idle; the block does not enforce this. The write channel is always ready.
module cycle_count_to_time_of_day
    import cctod_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [CountW-1:0] cycle_count,
    input  logic              zone_requested,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [CountW-1:0] seconds,
    output logic [NsW-1:0]    nanoseconds,
    output logic [UsW-1:0]    microseconds,
    output logic              fallback,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [IdxW-1:0]   cfg_index,
    input  logic [CfgW-1:0]   cfg_data
);

    logic [OsecW-1:0] osec_reg;
    logic [NsW-1:0]   ons_reg;
    logic [RateW-1:0] rate_reg;
    logic             len_reg;
    logic             advance;
    logic [NsW-1:0]   base_ns;

    cell_t chain_a [0:CellsA];
    cell_t chain_b [0:CellsB];

    logic              mul_valid_reg;
    logic              mul_fb_reg;
    logic [CountW-1:0] mul_prod_reg;
    logic [CountW-1:0] mul_whole_reg;

    logic              sum_valid_reg;
    logic              sum_fb_reg;
    logic [CountW-1:0] sum_sec_reg;
    logic [NsW-1:0]    sum_ns_reg;
    logic [NsW:0]      ns_total;
    logic              ns_carry;
    logic [NsW-1:0]    ns_norm;

    logic              out_valid_reg;
    logic [CountW-1:0] sec_reg;
    logic [NsW-1:0]    ns_reg;
    logic [UsW-1:0]    us_reg;
    logic              fb_reg;
    logic [60:0]       us_prod;

    assign cfg_ready = 1'b1;
    assign advance   = !out_valid_reg || !out_stall;
    assign in_stall  = !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            osec_reg <= '0;
            ons_reg  <= '0;
            rate_reg <= RATE_RESET;
            len_reg  <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_ORIGIN_SEC: osec_reg <= cfg_data[OsecW-1:0];
                REG_ORIGIN_NS:  ons_reg  <= cfg_data[NsW-1:0];
                REG_RATE:       rate_reg <= cfg_data[RateW-1:0];
                REG_LOCAL_EN:   len_reg  <= cfg_data[0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        chain_a[0].valid = in_valid;
        chain_a[0].fb    = !len_reg || zone_requested || (rate_reg == '0);
        chain_a[0].rem   = '0;
        chain_a[0].dvd   = cycle_count;
        chain_a[0].quo   = '0;
        chain_a[0].aux   = '0;
    end

    for (genvar i = 0; i < CellsA; i++)
    begin : g_div_a
        cctod_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .advance  (advance),
            .rate     (rate_reg),
            .cell_in  (chain_a[i]),
            .cell_out (chain_a[i+1])
        );
    end

    // Remainder times 10^9 stays below rate * 2^30, so it fits 64 bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            mul_valid_reg <= chain_a[CellsA].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            mul_fb_reg    <= chain_a[CellsA].fb;
            mul_prod_reg  <= {{(CountW-RateW){1'b0}}, chain_a[CellsA].rem}
                             * {{(CountW-NsW){1'b0}}, NS_ONE_SEC};
            mul_whole_reg <= chain_a[CellsA].quo;
        end
    end

    // The top of the product is already below the rate, so only the low
    // bits need a cell each.
    always_comb
    begin
        chain_b[0].valid = mul_valid_reg;
        chain_b[0].fb    = mul_fb_reg;
        chain_b[0].rem   = mul_prod_reg[CountW-1:NsW];
        chain_b[0].dvd   = {mul_prod_reg[NsW-1:0], {(CountW-NsW){1'b0}}};
        chain_b[0].quo   = '0;
        chain_b[0].aux   = mul_whole_reg;
    end

    for (genvar j = 0; j < CellsB; j++)
    begin : g_div_b
        cctod_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .advance  (advance),
            .rate     (rate_reg),
            .cell_in  (chain_b[j]),
            .cell_out (chain_b[j+1])
        );
    end

    always_comb
    begin
        base_ns  = (ons_reg > NS_MAX) ? NS_MAX : ons_reg;
        ns_total = {1'b0, base_ns} + {1'b0, chain_b[CellsB].quo[NsW-1:0]};
        ns_carry = ns_total >= {1'b0, NS_ONE_SEC};
        ns_norm  = ns_carry ? NsW'(ns_total - {1'b0, NS_ONE_SEC}) : ns_total[NsW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            sum_valid_reg <= chain_b[CellsB].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            sum_fb_reg  <= chain_b[CellsB].fb;
            sum_ns_reg  <= ns_norm;
            sum_sec_reg <= {{(CountW-OsecW){1'b0}}, osec_reg} + chain_b[CellsB].aux
                           + {{(CountW-1){1'b0}}, ns_carry};
        end
    end

    assign us_prod = {31'b0, sum_ns_reg} * {30'b0, US_RECIP};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= sum_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            fb_reg <= sum_fb_reg;
            if (sum_fb_reg)
            begin
                sec_reg <= '0;
                ns_reg  <= '0;
                us_reg  <= '0;
            end
            else
            begin
                sec_reg <= sum_sec_reg;
                ns_reg  <= sum_ns_reg;
                us_reg  <= us_prod[US_SHIFT+UsW-1:US_SHIFT];
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign seconds      = sec_reg;
    assign nanoseconds  = ns_reg;
    assign microseconds = us_reg;
    assign fallback     = fb_reg;

endmodule

/* hdl/cctod_checker.sv */
// ----------------------------------------------------------------------------
// Cycle count to time of day: port checker
// Watches the top-level ports and flags results that break the contract.
// ----------------------------------------------------------------------------
module cctod_checker
    import cctod_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              out_valid,
    input  logic              out_stall,
    input  logic [CountW-1:0] seconds,
    input  logic [NsW-1:0]    nanoseconds,
    input  logic [UsW-1:0]    microseconds,
    input  logic              fallback
);

    // A stalled result must stay valid with seconds and nanoseconds held.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(seconds) && $stable(nanoseconds))
        else $error("stalled result changed");

    a_fb_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && fallback |-> seconds == '0 && nanoseconds == '0 && microseconds == '0)
        else $error("fallback result carries a time");

    a_ns_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> nanoseconds < NS_ONE_SEC)
        else $error("nanoseconds not normalised");

    a_us_match: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> {10'b0, microseconds} * 30'd1000 <= nanoseconds
                      && nanoseconds - {10'b0, microseconds} * 30'd1000 < 30'd1000)
        else $error("microseconds disagree with nanoseconds");

endmodule

bind cycle_count_to_time_of_day cctod_checker u_cctod_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .seconds      (seconds),
    .nanoseconds  (nanoseconds),
    .microseconds (microseconds),
    .fallback     (fallback)
);
